// File: src/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: src/ssbd_pkg.sv
`default_nettype none
package ssbd_pkg;
  localparam int INTERNAL_WIDTH_D = 24;
  localparam int COEF_WIDTH_D = 18;
  localparam int HILBERT_TAPS_D = 31;
  localparam int ALIGN_DELAY_D = 16;
  localparam int FRAC_BITS = 8;
  localparam int GAIN_W = 20;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LSB_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd76800;

  typedef struct packed {
    logic signed [7:0] i_sample;
    logic signed [7:0] q_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic clipped;
  } out_item_t;

  // datapath commands
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_S1 = 3'd1;
  localparam logic [2:0] OP_S2 = 3'd2;
  localparam logic [2:0] OP_S3 = 3'd3;
  localparam logic [2:0] OP_HIL = 3'd4;
  localparam logic [2:0] OP_POST = 3'd5;

  typedef struct packed {
    logic load;
    logic start;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

  function automatic longint coef_e7(input longint e7, input int cw);
    longint m;
    longint r;
    m = (e7 < 0) ? -e7 : e7;
    r = (m * (longint'(1) << (cw - 1)) + 64'sd5000000) / 64'sd10000000;
    return (e7 < 0) ? -r : r;
  endfunction

  function automatic longint s1_e7(input int k);
    case (k)
      0, 7: return 273576;
      1, 6: return 863889;
      2, 5: return 1643134;
      default: return 2208413;
    endcase
  endfunction

  function automatic longint s2_e7(input int k);
    case (k)
      0, 11: return -193717;
      1, 10: return -35725;
      2, 9: return 346554;
      3, 8: return 1014222;
      4, 7: return 1752242;
      default: return 2239757;
    endcase
  endfunction

  function automatic longint s3_e7(input int k);
    case (k)
      0, 15: return -28484;
      1, 14: return 303700;
      2, 13: return 217396;
      3, 12: return -308793;
      4, 11: return -721113;
      5, 10: return 3860;
      6, 9: return 1955291;
      default: return 3725031;
    endcase
  endfunction

  function automatic longint hil_e7(input int d);
    case (d)
      0: return -33953;
      2: return -58652;
      4: return -134385;
      6: return -281423;
      8: return -534836;
      10: return -980394;
      12: return -1935638;
      14: return -6302204;
      16: return 6302204;
      18: return 1935638;
      20: return 980394;
      22: return 534836;
      24: return 281423;
      26: return 134385;
      28: return 58652;
      30: return 33953;
      default: return 0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: src/ssb_phasing_demodulator.sv
// channel | ports                            | payload
// in      | in_valid / in_ready / in_data    | i_sample, q_sample
// out     | out_valid / out_ready / out_data | pcm_sample, clipped
// cfg     | cfg_we / cfg_idx / cfg_data      | lsb_mode, gain
// one shared mac pair runs the stage 1/2/3 filter steps and the hilbert fir,
// then the dc blocker and gain run as the last step
// one result per 32 inputs
// synchronous active-low reset clears all filter lines
// input stalls while any step runs; the last step also waits on a pending result
`default_nettype none
module ssb_phasing_demodulator #(
  parameter int INTERNAL_WIDTH = ssbd_pkg::INTERNAL_WIDTH_D,
  parameter int COEF_WIDTH = ssbd_pkg::COEF_WIDTH_D,
  parameter int HILBERT_TAPS = ssbd_pkg::HILBERT_TAPS_D,
  parameter int ALIGN_DELAY = ssbd_pkg::ALIGN_DELAY_D
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire ssbd_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output ssbd_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [ssbd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ssbd_pkg::GAIN_W-1:0] cfg_data
);
  import ssbd_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic lsb_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsb_r <= 1'b1;
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LSB_MODE: lsb_r <= cfg_data[0];
        REG_GAIN: gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ssbd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  ssbd_datapath #(
    .INTERNAL_WIDTH(INTERNAL_WIDTH), .COEF_WIDTH(COEF_WIDTH),
    .HILBERT_TAPS(HILBERT_TAPS), .ALIGN_DELAY(ALIGN_DELAY)
  ) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .lsb_mode(lsb_r), .gain(gain_r), .out_data
  );
endmodule
`default_nettype wire

// File: src/ssbd_ctrl.sv
`default_nettype none
module ssbd_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output ssbd_pkg::cmd_t cmd,
  input  wire ssbd_pkg::stat_t stat
);
  import ssbd_pkg::*;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1 = 3'd1;
  localparam logic [2:0] ST_S2 = 3'd2;
  localparam logic [2:0] ST_S3 = 3'd3;
  localparam logic [2:0] ST_HIL = 3'd4;
  localparam logic [2:0] ST_POST = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] ph_r, ph_nxt;
  logic [4:0] cur_r, cur_nxt;
  logic started_r, started_nxt;
  logic pend_r, pend_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = pend_r;

  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    cur_nxt = cur_r;
    started_nxt = 1'b0;
    pend_nxt = pend_r && !out_ready;
    cmd = '0;
    cmd.op = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cur_nxt = ph_r;
          ph_nxt = ph_r + 5'd1;
          if (ph_r[1:0] == 2'd3) state_nxt = ST_S1;
        end
      end
      ST_S1, ST_S2, ST_S3, ST_HIL, ST_POST: begin
        cmd.op = state_r;
        // the gain step waits until the previous result has left
        cmd.start = !started_r && !((state_r == ST_POST) && pend_r);
        started_nxt = started_r || cmd.start;
        if (started_r && stat.done) begin
          started_nxt = 1'b0;
          case (state_r)
            ST_S1: state_nxt = (cur_r[3:0] == 4'hf) ? ST_S2 : ST_IDLE;
            ST_S2: state_nxt = (cur_r == 5'd31) ? ST_S3 : ST_IDLE;
            ST_S3: state_nxt = ST_HIL;
            ST_HIL: state_nxt = ST_POST;
            default: begin
              state_nxt = ST_IDLE;
              pend_nxt = 1'b1;
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r <= '0;
      cur_r <= '0;
      started_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      cur_r <= cur_nxt;
      started_r <= started_nxt;
      pend_r <= pend_nxt;
    end
  end
endmodule
`default_nettype wire

// File: src/ssbd_datapath.sv
`default_nettype none
module ssbd_datapath #(
  parameter int INTERNAL_WIDTH = ssbd_pkg::INTERNAL_WIDTH_D,
  parameter int COEF_WIDTH = ssbd_pkg::COEF_WIDTH_D,
  parameter int HILBERT_TAPS = ssbd_pkg::HILBERT_TAPS_D,
  parameter int ALIGN_DELAY = ssbd_pkg::ALIGN_DELAY_D
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ssbd_pkg::in_item_t in_data,
  input  wire ssbd_pkg::cmd_t cmd,
  output ssbd_pkg::stat_t stat,
  input  wire logic lsb_mode,
  input  wire logic [ssbd_pkg::GAIN_W-1:0] gain,
  output ssbd_pkg::out_item_t out_data
);
  import ssbd_pkg::*;
  localparam int W = INTERNAL_WIDTH;
  localparam int CF = COEF_WIDTH - 1;
  localparam int AW = W + COEF_WIDTH + 8;
  localparam int PW = W + COEF_WIDTH;
  localparam int CNT_W = $clog2(HILBERT_TAPS + 2);
  localparam int HW = $clog2(HILBERT_TAPS);
  localparam int CENTER = (HILBERT_TAPS - 1) / 2;
  localparam int TAB_N = 64;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0] DC_POLE =
    COEF_WIDTH'(coef_e7(9500000, COEF_WIDTH));

  // coefficient tables, one entry per tap, zero-padded to 64 entries
  function automatic logic [TAB_N*COEF_WIDTH-1:0] mk_tab(input logic [2:0] op);
    logic [TAB_N*COEF_WIDTH-1:0] r;
    longint e;
    int d;
    r = '0;
    for (int k = 0; k < TAB_N; k++) begin
      d = k - CENTER + 15;
      case (op)
        OP_S1: e = (k < 8) ? s1_e7(k) : 0;
        OP_S2: e = (k < 12) ? s2_e7(k) : 0;
        OP_S3: e = (k < 16) ? s3_e7(k) : 0;
        default: e = (k < HILBERT_TAPS && d >= 0 && d < 31) ? hil_e7(d) : 0;
      endcase
      r[k*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'(coef_e7(e, COEF_WIDTH));
    end
    return r;
  endfunction

  localparam logic [TAB_N*COEF_WIDTH-1:0] TAB_S1 = mk_tab(OP_S1);
  localparam logic [TAB_N*COEF_WIDTH-1:0] TAB_S2 = mk_tab(OP_S2);
  localparam logic [TAB_N*COEF_WIDTH-1:0] TAB_S3 = mk_tab(OP_S3);
  localparam logic [TAB_N*COEF_WIDTH-1:0] TAB_HIL = mk_tab(OP_HIL);

  logic signed [W-1:0] i1_r [8], q1_r [8];
  logic signed [W-1:0] i2_r [12], q2_r [12];
  logic signed [W-1:0] i3_r [16], q3_r [16];
  logic signed [W-1:0] al_r [ALIGN_DELAY];
  logic signed [W-1:0] hl_r [HILBERT_TAPS];
  logic signed [W-1:0] dcx_r, dcy_r;
  logic signed [W-1:0] qh_r;
  logic signed [AW-1:0] acc_i_r, acc_q_r;
  logic signed [PW-1:0] pi_r, pq_r;
  logic [CNT_W-1:0] k_r;
  logic pv_r;
  logic busy_r;
  logic [2:0] op_r;
  logic [1:0] post_r;
  logic signed [W+1:0] xs_r;
  logic signed [W+GAIN_W+1:0] prod_r;
  logic signed [W-1:0] ta, tb;
  logic signed [COEF_WIDTH-1:0] c;
  logic [CNT_W-1:0] ntaps;
  logic last;
  logic signed [W-1:0] ri, rq;
  int sh;

  function automatic logic signed [W-1:0] rnd_sat(input logic signed [AW-1:0] a,
                                                   input int s);
    logic signed [AW-1:0] v;
    v = (s == 0) ? a : ((a + (AW'(1) <<< (s - 1))) >>> s);
    if (v > AW'(SMAX)) return SMAX;
    if (v < AW'(SMIN)) return SMIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] a);
    if (a > (W+2)'(SMAX)) return SMAX;
    if (a < (W+2)'(SMIN)) return SMIN;
    return a[W-1:0];
  endfunction

  always_comb begin
    ta = '0;
    tb = '0;
    c = '0;
    ntaps = '0;
    sh = CF;
    case (op_r)
      OP_S1: begin
        ntaps = CNT_W'(8);
        sh = CF - FRAC_BITS;
        if (k_r < CNT_W'(8)) begin
          ta = i1_r[k_r[2:0]];
          tb = q1_r[k_r[2:0]];
          c = TAB_S1[int'(k_r[2:0])*COEF_WIDTH +: COEF_WIDTH];
        end
      end
      OP_S2: begin
        ntaps = CNT_W'(12);
        if (k_r < CNT_W'(12)) begin
          ta = i2_r[k_r[3:0]];
          tb = q2_r[k_r[3:0]];
          c = TAB_S2[int'(k_r[3:0])*COEF_WIDTH +: COEF_WIDTH];
        end
      end
      OP_S3: begin
        ntaps = CNT_W'(16);
        if (k_r < CNT_W'(16)) begin
          ta = i3_r[k_r[3:0]];
          tb = q3_r[k_r[3:0]];
          c = TAB_S3[int'(k_r[3:0])*COEF_WIDTH +: COEF_WIDTH];
        end
      end
      OP_HIL: begin
        ntaps = CNT_W'(HILBERT_TAPS);
        if (k_r < CNT_W'(HILBERT_TAPS)) begin
          tb = hl_r[k_r[HW-1:0]];
          c = TAB_HIL[int'(k_r[HW-1:0])*COEF_WIDTH +: COEF_WIDTH];
        end
      end
      default: ;
    endcase
  end

  assign last = busy_r && (k_r == ntaps + CNT_W'(1));
  assign ri = rnd_sat(acc_i_r + AW'(pi_r), sh);
  assign rq = rnd_sat(acc_q_r + AW'(pq_r), sh);
  assign stat.done = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r <= OP_NONE;
      k_r <= '0;
      pv_r <= 1'b0;
      post_r <= '0;
      dcx_r <= '0;
      dcy_r <= '0;
      for (int j = 0; j < 8; j++) begin i1_r[j] <= '0; q1_r[j] <= '0; end
      for (int j = 0; j < 12; j++) begin i2_r[j] <= '0; q2_r[j] <= '0; end
      for (int j = 0; j < 16; j++) begin i3_r[j] <= '0; q3_r[j] <= '0; end
      for (int j = 0; j < ALIGN_DELAY; j++) al_r[j] <= '0;
      for (int j = 0; j < HILBERT_TAPS; j++) hl_r[j] <= '0;
    end else begin
      if (cmd.load) begin
        for (int j = 7; j > 0; j--) begin i1_r[j] <= i1_r[j-1]; q1_r[j] <= q1_r[j-1]; end
        i1_r[0] <= W'(in_data.i_sample);
        q1_r[0] <= W'(in_data.q_sample);
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        op_r <= cmd.op;
        k_r <= '0;
        pv_r <= 1'b0;
        post_r <= '0;
        acc_i_r <= '0;
        acc_q_r <= '0;
      end else if (busy_r && op_r == OP_POST) begin
        post_r <= post_r + 2'd1;
        case (post_r)
          2'd0: xs_r <= lsb_mode ? (W+2)'(al_r[ALIGN_DELAY-1]) + (W+2)'(qh_r)
                                 : (W+2)'(al_r[ALIGN_DELAY-1]) - (W+2)'(qh_r);
          2'd1: begin
            pi_r <= PW'(DC_POLE) * PW'(dcy_r);
            xs_r <= (W+2)'(sat_w(xs_r));
          end
          2'd2: begin
            dcx_r <= xs_r[W-1:0];
            dcy_r <= sat_w((W+2)'(xs_r) - (W+2)'(dcx_r) +
                           (W+2)'(rnd_sat(AW'(pi_r), CF)));
          end
          default: begin
            prod_r <= (W+GAIN_W+2)'(dcy_r) * (W+GAIN_W+2)'($signed({1'b0, gain}));
            busy_r <= 1'b0;
          end
        endcase
      end else if (busy_r) begin
        k_r <= k_r + CNT_W'(1);
        pi_r <= PW'(c) * PW'(ta);
        pq_r <= PW'(c) * PW'(tb);
        pv_r <= 1'b1;
        if (pv_r && !last) begin
          acc_i_r <= acc_i_r + AW'(pi_r);
          acc_q_r <= acc_q_r + AW'(pq_r);
        end
        if (last) begin
          busy_r <= 1'b0;
          case (op_r)
            OP_S1: begin
              for (int j = 11; j > 0; j--) begin i2_r[j] <= i2_r[j-1]; q2_r[j] <= q2_r[j-1]; end
              i2_r[0] <= ri;
              q2_r[0] <= rq;
            end
            OP_S2: begin
              for (int j = 15; j > 0; j--) begin i3_r[j] <= i3_r[j-1]; q3_r[j] <= q3_r[j-1]; end
              i3_r[0] <= ri;
              q3_r[0] <= rq;
            end
            OP_S3: begin
              for (int j = ALIGN_DELAY-1; j > 0; j--) al_r[j] <= al_r[j-1];
              al_r[0] <= ri;
              for (int j = HILBERT_TAPS-1; j > 0; j--) hl_r[j] <= hl_r[j-1];
              hl_r[0] <= rq;
            end
            default: qh_r <= rq;
          endcase
        end
      end
    end
  end

  logic signed [W+GAIN_W+1:0] mag;
  logic signed [W+GAIN_W+1:0] t;
  always_comb begin
    mag = prod_r < 0 ? -prod_r : prod_r;
    t = mag >>> 16;
    if (prod_r < 0) t = -t;
    out_data.clipped = 1'b0;
    out_data.pcm_sample = t[15:0];
    if (t > 32767) begin
      out_data.pcm_sample = 16'sh7fff;
      out_data.clipped = 1'b1;
    end else if (t < -32768) begin
      out_data.pcm_sample = 16'sh8000;
      out_data.clipped = 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: src/ssbd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ssbd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [16:0] out_data
);
  `ASSERT_IMP(a_known, clk, rst_n, out_valid, !$isunknown(out_data))
  `ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMP(a_clip, clk, rst_n, out_valid && out_data[0],
    out_data[16:1] == 16'h7fff || out_data[16:1] == 16'h8000)
  `ASSERT_IMP(a_rdy_known, clk, rst_n, in_valid, !$isunknown(in_ready))
endmodule
bind ssb_phasing_demodulator ssbd_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
